// ===== rtl/mfd_pkg.sv =====
package mfd_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;
    localparam int RATE_W     = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_RATE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_RATE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ONLINE_RELOAD = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_FRAMES = 2'd3;

    localparam logic [RATE_W-1:0] Q_ONE             = 17'd65536;
    localparam logic [7:0]        ONLINE_RELOAD_RST = 8'd100;
    localparam logic [7:0]        OFFSET_FRAMES_RST = 8'd50;

    localparam logic OP_FRAME = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // reciprocal of five in Q0.18, exact for any 16-bit magnitude
    localparam logic [15:0] RECIP5_Q18 = 16'd52429;

    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 96;
    localparam int SUM_W      = 20;

    typedef struct packed {
        logic [2:0]         pad;
        logic [15:0]        interval;
        logic [7:0]         temperature;
        logic signed [15:0] current_raw;
        logic signed [15:0] speed_raw;
        logic [12:0]        rotor_angle;
    } in_data_t;

    typedef struct packed {
        logic [2:0]         pad;
        logic               offset_phase;
        logic               window_full;
        logic [SUM_W-1:0]   interval_sum;
        logic               online;
        logic [7:0]         temperature_out;
        logic signed [13:0] current_filtered;
        logic signed [15:0] speed_filtered;
        logic signed [31:0] multiturn_angle;
    } out_data_t;

endpackage

// ===== rtl/mfd_lpf.sv =====
module mfd_lpf
(
    input  logic signed [31:0]                 state_old,
    input  logic signed [15:0]                 sample,
    input  logic [mfd_pkg::RATE_W-1:0]         rate,
    output logic signed [31:0]                 state_new
);

    logic [mfd_pkg::RATE_W-1:0] rate_sat;
    logic signed [32:0]         diff;
    logic signed [50:0]         prod;
    logic signed [34:0]         step;

    // new = old + floor(r * ((sample << 16) - old) / 2^16)
    always_comb
    begin
        rate_sat  = (rate > mfd_pkg::Q_ONE) ? mfd_pkg::Q_ONE : rate;
        diff      = $signed({sample[15], sample, 16'b0}) - $signed({state_old[31], state_old});
        prod      = $signed({1'b0, rate_sat}) * diff;
        step      = 35'(prod >>> 16);
        state_new = 32'(step + 35'(state_old));
    end

endmodule

// ===== rtl/motor_feedback_decoder_top.sv =====
// Motor feedback decoder.
// Slave stream: s_tuser carries op (frame or tick), s_tdata the frame fields.
// Master stream: one result transaction per input transaction, in order.
// Configuration: cfg_we writes cfg_data to register cfg_index;
// write only while no transaction is in flight.
// Path: the result is registered behind an input stage that holds the current
// sample divided by -5, then the state update stage whose filter multipliers
// and angle unwrap feed the result register.
// Throughput: one transaction per cycle while m_tready keeps the result stage
// free; the state update closes its loop combinationally into its registers.
// Reset: state registers clear, config registers take defaults, both stream
// stages empty. The interval window fills over WINDOW_DEPTH decoded frames.
// Stall: a held result keeps m_tdata stable; the input stage still accepts
// one more transaction, then s_tready drops until m_tready returns.
module motor_feedback_decoder_top
#(
    parameter int WINDOW_DEPTH   = 10,
    parameter int ENCODER_COUNTS = 8192
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // rotor_angle, speed_raw, current_raw, temperature, interval, zero pad
    input  logic [mfd_pkg::IN_DATA_W-1:0]   s_tdata,
    // op
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // multiturn_angle, speed_filtered, current_filtered, temperature_out, online,
    // interval_sum, window_full, offset_phase, zero pad
    output logic [mfd_pkg::OUT_DATA_W-1:0]  m_tdata,
    input  logic                            cfg_we,
    input  logic [mfd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mfd_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int IW = $clog2(WINDOW_DEPTH);
    localparam logic [IW-1:0]      LAST_IDX = IW'(WINDOW_DEPTH - 1);
    localparam logic signed [17:0] HALF_S   = 18'(ENCODER_COUNTS / 2);
    localparam logic [31:0]        COUNTS   = 32'(ENCODER_COUNTS);

    mfd_pkg::in_data_t  s_item;
    mfd_pkg::out_data_t res_next;
    mfd_pkg::out_data_t res_reg;

    logic [mfd_pkg::RATE_W-1:0] speed_rate_reg;
    logic [mfd_pkg::RATE_W-1:0] current_rate_reg;
    logic [7:0]                 online_reload_reg;
    logic [7:0]                 offset_frames_reg;

    logic               in_valid_reg;
    logic               op_reg;
    logic [12:0]        angle_reg;
    logic signed [15:0] speed_in_reg;
    logic signed [13:0] cur_div_reg;
    logic [7:0]         temp_in_reg;
    logic [15:0]        interval_in_reg;
    logic               out_valid_reg;
    logic               out_load;

    logic [15:0]        cur_mag;
    logic [31:0]        cur_prod;
    logic [12:0]        cur_quot;
    logic signed [13:0] cur_div;

    logic [8:0]          frame_count_reg, frame_count_next;
    logic [12:0]         angle_now_reg, angle_now_next;
    logic [12:0]         angle_offset_reg, angle_offset_next;
    logic [31:0]         turn_count_reg, turn_count_next;
    logic signed [31:0]  speed_state_reg, speed_state_next, speed_lpf;
    logic signed [31:0]  current_state_reg, current_state_next, current_lpf;
    logic [7:0]          temp_hold_reg, temp_hold_next;
    logic [7:0]          online_count_reg, online_count_next;
    logic [IW-1:0]       ring_index_reg, ring_index_next;
    logic                ring_wrapped_reg, ring_wrapped_next;
    logic [mfd_pkg::SUM_W-1:0] interval_total_reg, interval_total_next;

    logic [15:0]         ring_mem [WINDOW_DEPTH];
    logic [15:0]         ring_rd_reg;
    logic                ring_we;
    logic                capture;
    logic                decode;
    logic signed [17:0]  angle_diff;
    logic signed [15:0]  cur_sample;
    logic [31:0]         total;

    assign s_item   = mfd_pkg::in_data_t'(s_tdata);
    assign out_load = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || out_load;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_rate_reg    <= mfd_pkg::Q_ONE;
            current_rate_reg  <= mfd_pkg::Q_ONE;
            online_reload_reg <= mfd_pkg::ONLINE_RELOAD_RST;
            offset_frames_reg <= mfd_pkg::OFFSET_FRAMES_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mfd_pkg::CFG_SPEED_RATE:    speed_rate_reg    <= cfg_data;
                mfd_pkg::CFG_CURRENT_RATE:  current_rate_reg  <= cfg_data;
                mfd_pkg::CFG_ONLINE_RELOAD: online_reload_reg <= cfg_data[7:0];
                mfd_pkg::CFG_OFFSET_FRAMES: offset_frames_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // current / -5, truncated toward zero
    always_comb
    begin
        cur_mag  = s_item.current_raw[15] ? 16'(-s_item.current_raw) : s_item.current_raw;
        cur_prod = cur_mag * mfd_pkg::RECIP5_Q18;
        cur_quot = cur_prod[30:18];
        cur_div  = s_item.current_raw[15] ? $signed({1'b0, cur_quot})
                                          : -$signed({1'b0, cur_quot});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            op_reg          <= s_tuser;
            angle_reg       <= s_item.rotor_angle;
            speed_in_reg    <= s_item.speed_raw;
            cur_div_reg     <= cur_div;
            temp_in_reg     <= s_item.temperature;
            interval_in_reg <= s_item.interval;
        end
    end

    assign cur_sample = 16'(cur_div_reg);

    mfd_lpf u_speed_lpf
    (
        .state_old (speed_state_reg),
        .sample    (speed_in_reg),
        .rate      (speed_rate_reg),
        .state_new (speed_lpf)
    );

    mfd_lpf u_current_lpf
    (
        .state_old (current_state_reg),
        .sample    (cur_sample),
        .rate      (current_rate_reg),
        .state_new (current_lpf)
    );

    always_comb
    begin
        capture    = (op_reg == mfd_pkg::OP_FRAME) && (frame_count_reg <= {1'b0, offset_frames_reg});
        decode     = (op_reg == mfd_pkg::OP_FRAME) && !capture;
        angle_diff = $signed({5'b0, angle_reg}) - $signed({5'b0, angle_now_reg});
        ring_we    = out_load && decode;

        frame_count_next    = frame_count_reg;
        angle_now_next      = angle_now_reg;
        angle_offset_next   = angle_offset_reg;
        turn_count_next     = turn_count_reg;
        speed_state_next    = speed_state_reg;
        current_state_next  = current_state_reg;
        temp_hold_next      = temp_hold_reg;
        online_count_next   = online_count_reg;
        ring_index_next     = ring_index_reg;
        ring_wrapped_next   = ring_wrapped_reg;
        interval_total_next = interval_total_reg;

        if (op_reg == mfd_pkg::OP_TICK)
        begin
            if (online_count_reg != 8'd0)
            begin
                online_count_next = online_count_reg - 8'd1;
            end
        end
        else if (capture)
        begin
            angle_now_next    = angle_reg;
            angle_offset_next = angle_reg;
            frame_count_next  = frame_count_reg + 9'd1;
        end
        else
        begin
            angle_now_next = angle_reg;
            if (angle_diff > HALF_S)
            begin
                turn_count_next = turn_count_reg - 32'd1;
            end
            else if (angle_diff < -HALF_S)
            begin
                turn_count_next = turn_count_reg + 32'd1;
            end
            speed_state_next   = speed_lpf;
            current_state_next = current_lpf;
            temp_hold_next     = temp_in_reg;
            online_count_next  = online_reload_reg;
            interval_total_next = interval_total_reg + mfd_pkg::SUM_W'(interval_in_reg)
                                - (ring_wrapped_reg ? mfd_pkg::SUM_W'(ring_rd_reg)
                                                    : mfd_pkg::SUM_W'(0));
            if (ring_index_reg == LAST_IDX)
            begin
                ring_index_next   = '0;
                ring_wrapped_next = 1'b1;
            end
            else
            begin
                ring_index_next = ring_index_reg + IW'(1);
            end
        end

        total = 32'(turn_count_next * COUNTS) + 32'(angle_now_next) - 32'(angle_offset_next);

        res_next.pad              = '0;
        res_next.multiturn_angle  = total;
        res_next.speed_filtered   = speed_state_next[31:16];
        res_next.current_filtered = current_state_next[29:16];
        res_next.temperature_out  = temp_hold_next;
        res_next.online           = online_count_next != 8'd0;
        res_next.interval_sum     = interval_total_next;
        res_next.window_full      = ring_wrapped_next;
        res_next.offset_phase     = frame_count_next <= {1'b0, offset_frames_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg    <= '0;
            angle_now_reg      <= '0;
            angle_offset_reg   <= '0;
            turn_count_reg     <= '0;
            speed_state_reg    <= '0;
            current_state_reg  <= '0;
            temp_hold_reg      <= '0;
            online_count_reg   <= '0;
            ring_index_reg     <= '0;
            ring_wrapped_reg   <= 1'b0;
            interval_total_reg <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                frame_count_reg    <= frame_count_next;
                angle_now_reg      <= angle_now_next;
                angle_offset_reg   <= angle_offset_next;
                turn_count_reg     <= turn_count_next;
                speed_state_reg    <= speed_state_next;
                current_state_reg  <= current_state_next;
                temp_hold_reg      <= temp_hold_next;
                online_count_reg   <= online_count_next;
                ring_index_reg     <= ring_index_next;
                ring_wrapped_reg   <= ring_wrapped_next;
                interval_total_reg <= interval_total_next;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            res_reg <= res_next;
        end
    end

    // prefetch the entry that the next frame retires
    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_mem[ring_index_reg] <= interval_in_reg;
        end
        ring_rd_reg <= ring_mem[out_load ? ring_index_next : ring_index_reg];
    end

    a_ring_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        ring_index_reg <= LAST_IDX)
        else $error("ring index beyond window");

    a_wrap_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ring_wrapped_reg) |-> ring_index_reg == '0)
        else $error("window marked full away from index zero");

    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !out_load |=> in_valid_reg)
        else $error("input stage lost a transaction");

    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> in_valid_reg && out_valid_reg && !m_tready)
        else $error("input stalled without a downstream stall");

    a_reload: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && decode |=> online_count_reg == $past(online_reload_reg))
        else $error("decoded frame did not reload the countdown");

endmodule
